// File: sv/cmr_pkg.sv
// ----------------------------------------------------------------------------
// cmr_pkg: shared types and constants of the motor response reassembler
// Holds the decoded result layout, the packet head snapshot, register
// indexes, response kinds and the reset values of the configuration.
// ----------------------------------------------------------------------------
package cmr_pkg;

  // Only the first seven packet bytes are ever decoded.
  localparam int HEAD_BYTES = 7;
  localparam int FRAME_BYTES = 8;

  localparam logic [3:0] MAX_FRAME_COUNT = 4'd8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FIRST_ADDR    = 3'd0;
  localparam logic [2:0] CFG_SECOND_ADDR   = 3'd1;
  localparam logic [2:0] CFG_CODE_POS      = 3'd2;
  localparam logic [2:0] CFG_CODE_SPEED    = 3'd3;
  localparam logic [2:0] CFG_CODE_STATUS   = 3'd4;
  localparam logic [2:0] CFG_CODE_POS_ERR  = 3'd5;
  localparam logic [2:0] CFG_CODE_HOME     = 3'd6;

  // Configuration reset values.
  localparam logic [7:0] RST_FIRST_ADDR   = 8'd1;
  localparam logic [7:0] RST_SECOND_ADDR  = 8'd2;
  localparam logic [7:0] RST_CODE_POS     = 8'd54;
  localparam logic [7:0] RST_CODE_SPEED   = 8'd53;
  localparam logic [7:0] RST_CODE_STATUS  = 8'd58;
  localparam logic [7:0] RST_CODE_POS_ERR = 8'd55;
  localparam logic [7:0] RST_CODE_HOME    = 8'd59;

  // Response kinds.
  localparam logic [2:0] KIND_POSITION  = 3'd0;
  localparam logic [2:0] KIND_SPEED     = 3'd1;
  localparam logic [2:0] KIND_STATUS    = 3'd2;
  localparam logic [2:0] KIND_POS_ERROR = 3'd3;
  localparam logic [2:0] KIND_HOME      = 3'd4;

  typedef logic [HEAD_BYTES-1:0][7:0] head_t;

  typedef struct packed {
    logic [7:0] position;
    logic [7:0] speed;
    logic [7:0] status;
    logic [7:0] pos_err;
    logic [7:0] home_status;
  } code_cfg_t;

  // Completed packet as seen by the decoder.
  typedef struct packed {
    logic  motor;
    head_t head;
    logic  len_ge3;
    logic  len_ge5;
    logic  len_ge7;
  } snap_t;

  typedef struct packed {
    logic        which_motor;
    logic [2:0]  response_kind;
    logic        negative;
    logic [31:0] magnitude;
    logic [7:0]  status_value;
    logic        enabled;
  } result_t;

endpackage

// File: sv/cmr_channels.sv
// ----------------------------------------------------------------------------
// cmr_channels: handshake channels of the motor response reassembler
// Frame input, decoded result output and configuration write channel.
// ----------------------------------------------------------------------------
interface cmr_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [3:0]  byte_count;
  logic [63:0] payload;

  modport source (output valid, frame_id, byte_count, payload, input ready);
  modport sink (input valid, frame_id, byte_count, payload, output ready);
endinterface

interface cmr_result_if;
  logic        valid;
  logic        ready;
  logic        which_motor;
  logic [2:0]  response_kind;
  logic        negative;
  logic [31:0] magnitude;
  logic [7:0]  status_value;
  logic        enabled;

  modport source (output valid, which_motor, response_kind, negative, magnitude,
                  status_value, enabled, input ready);
  modport sink (input valid, which_motor, response_kind, negative, magnitude,
                status_value, enabled, output ready);
endinterface

interface cmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/cmr_byte_lane.sv
// ----------------------------------------------------------------------------
// cmr_byte_lane: next value of one packet head byte
// Each lane owns one byte position of the head and picks the frame byte
// that lands on it, or keeps the old byte.
// ----------------------------------------------------------------------------
module cmr_byte_lane
  import cmr_pkg::*;
#(
  parameter int LANE  = 0,
  parameter int LEN_W = 5
) (
  input  logic [LEN_W-1:0] base,
  input  logic             wr_en,
  input  logic [3:0]       count,
  input  logic [63:0]      payload,
  input  logic [7:0]       old_byte,
  output logic [7:0]       new_byte
);

  logic [FRAME_BYTES-1:0][7:0] frame_bytes;
  logic [LEN_W-1:0]            diff;
  logic                        reach;
  logic                        hit;

  assign frame_bytes = payload;
  assign reach = base <= LEN_W'(LANE);
  assign diff  = LEN_W'(LANE) - base;

  // The lane sits inside the frame's span when its offset from the write
  // start is below the byte count; the offset is under seven when reached.
  assign hit = wr_en && reach && ({1'b0, diff[2:0]} < count);

  always_comb begin
    if (hit) begin
      new_byte = frame_bytes[diff[2:0]];
    end else begin
      new_byte = old_byte;
    end
  end

endmodule

// File: sv/cmr_decode.sv
// ----------------------------------------------------------------------------
// cmr_decode: function code decoder of a completed packet
// Matches byte 0 against the configured codes in priority order and
// extracts sign, magnitude and status fields.
// ----------------------------------------------------------------------------
module cmr_decode
  import cmr_pkg::*;
(
  input  snap_t     snap,
  input  code_cfg_t codes,
  output logic      hit,
  output result_t   res
);

  logic [7:0] code;
  logic [7:0] b2;

  assign code = snap.head[0];
  assign b2   = snap.head[2];

  always_comb begin
    res             = '0;
    res.which_motor = snap.motor;
    hit             = 1'b0;
    // A short packet gives no result even if a later code would also match.
    if (code == codes.position) begin
      hit               = snap.len_ge7;
      res.response_kind = KIND_POSITION;
      res.negative      = b2 != 8'd0;
      res.magnitude     = {snap.head[3], snap.head[4], snap.head[5], snap.head[6]};
    end else if (code == codes.speed) begin
      hit               = snap.len_ge5;
      res.response_kind = KIND_SPEED;
      res.negative      = b2 != 8'd0;
      res.magnitude     = {16'd0, snap.head[3], snap.head[4]};
    end else if (code == codes.status) begin
      hit               = snap.len_ge3;
      res.response_kind = KIND_STATUS;
      res.status_value  = b2;
      res.enabled       = b2[0];
    end else if (code == codes.pos_err) begin
      hit               = snap.len_ge7;
      res.response_kind = KIND_POS_ERROR;
      res.magnitude     = {snap.head[3], snap.head[4], snap.head[5], snap.head[6]};
    end else if (code == codes.home_status) begin
      hit               = snap.len_ge3;
      res.response_kind = KIND_HOME;
      res.status_value  = b2;
    end
  end

endmodule

// File: sv/can_motor_response_reassembler.sv
// ----------------------------------------------------------------------------
// can_motor_response_reassembler: CAN motor response reassembly and decode
//
//   channel  role    carries
//   -------  ------  ---------------------------------------------------
//   frame    sink    frame_id, byte_count, payload of a received frame
//   result   source  which_motor, response_kind, negative, magnitude,
//                    status_value, enabled
//   cfg      sink    index, data of a register write (always ready)
//
// One frame is taken every cycle unless a result is stalled. After its frame
// transfer, a result passes the byte lanes that update the packet head into
// the decode stage, then the code decoder feeding the output register.
// Reset clears both packet lengths and the valid flags and resets the configuration.
// A stalled result holds the output register and the decode stage and
// deasserts frame.ready; nothing is dropped.
// ----------------------------------------------------------------------------
module can_motor_response_reassembler
  import cmr_pkg::*;
#(
  parameter int BUFFER_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  cmr_frame_if.sink           frame,
  cmr_result_if.source        result,
  cmr_cfg_if.sink             cfg
);

  localparam int LEN_W = $clog2(BUFFER_BYTES + 1);

  // Configuration registers.
  logic [7:0] first_motor_address;
  logic [7:0] second_motor_address;
  code_cfg_t  codes;

  // Per motor packet state; only the decoded head bytes are kept.
  head_t            head   [2];
  logic [LEN_W-1:0] length [2];

  snap_t   snap;
  logic    snap_valid;
  result_t out_data;
  logic    out_valid;

  logic             advance;
  logic             in_fire;
  logic [7:0]       addr;
  logic [7:0]       pkt;
  logic             hit0;
  logic             hit1;
  logic             matched;
  logic             m;
  logic [3:0]       count_c;
  logic             restart;
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W:0]   sum;
  logic             fits;
  logic             do_write;
  logic [LEN_W-1:0] base;
  logic [LEN_W-1:0] length_next;
  head_t            head_next;
  logic             complete;
  logic             dec_hit;
  result_t          dec_res;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_motor_address  <= RST_FIRST_ADDR;
      second_motor_address <= RST_SECOND_ADDR;
      codes.position       <= RST_CODE_POS;
      codes.speed          <= RST_CODE_SPEED;
      codes.status         <= RST_CODE_STATUS;
      codes.pos_err        <= RST_CODE_POS_ERR;
      codes.home_status    <= RST_CODE_HOME;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FIRST_ADDR:   first_motor_address  <= cfg.data;
        CFG_SECOND_ADDR:  second_motor_address <= cfg.data;
        CFG_CODE_POS:     codes.position       <= cfg.data;
        CFG_CODE_SPEED:   codes.speed          <= cfg.data;
        CFG_CODE_STATUS:  codes.status         <= cfg.data;
        CFG_CODE_POS_ERR: codes.pos_err        <= cfg.data;
        CFG_CODE_HOME:    codes.home_status    <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- frame intake
  assign advance     = !out_valid || result.ready;
  assign frame.ready = advance;
  assign in_fire     = frame.valid && advance;

  assign addr    = frame.frame_id[15:8];
  assign pkt     = frame.frame_id[7:0];
  assign hit0    = addr == first_motor_address;
  assign hit1    = addr == second_motor_address;
  assign matched = hit0 || hit1;
  assign m       = !hit0;

  assign count_c  = (frame.byte_count > MAX_FRAME_COUNT) ? MAX_FRAME_COUNT
                                                         : frame.byte_count;
  assign restart  = pkt == 8'd0;
  assign complete = count_c < MAX_FRAME_COUNT;
  assign cur_len  = length[m];
  assign sum      = {1'b0, cur_len} + (LEN_W + 1)'(count_c);
  assign fits     = sum <= (LEN_W + 1)'(BUFFER_BYTES);
  assign do_write = restart || fits;
  assign base     = restart ? '0 : cur_len;

  always_comb begin
    if (restart) begin
      length_next = LEN_W'(count_c);
    end else if (fits) begin
      length_next = sum[LEN_W-1:0];
    end else begin
      length_next = cur_len;
    end
  end

  for (genvar j = 0; j < HEAD_BYTES; j++) begin : g_lane
    cmr_byte_lane #(
      .LANE  (j),
      .LEN_W (LEN_W)
    ) u_lane (
      .base     (base),
      .wr_en    (do_write),
      .count    (count_c),
      .payload  (frame.payload),
      .old_byte (head[m][j]),
      .new_byte (head_next[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length[0] <= '0;
      length[1] <= '0;
    end else if (in_fire && matched) begin
      length[m] <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && matched) begin
      head[m] <= head_next;
    end
  end

  // ---------------------------------------------------------- decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (advance) begin
      snap_valid <= in_fire && matched && complete;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      snap.motor   <= m;
      snap.head    <= head_next;
      snap.len_ge3 <= length_next >= LEN_W'(3);
      snap.len_ge5 <= length_next >= LEN_W'(5);
      snap.len_ge7 <= length_next >= LEN_W'(7);
    end
  end

  cmr_decode u_decode (
    .snap  (snap),
    .codes (codes),
    .hit   (dec_hit),
    .res   (dec_res)
  );

  // --------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= snap_valid && dec_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= dec_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.which_motor   = out_data.which_motor;
  assign result.response_kind = out_data.response_kind;
  assign result.negative      = out_data.negative;
  assign result.magnitude     = out_data.magnitude;
  assign result.status_value  = out_data.status_value;
  assign result.enabled       = out_data.enabled;

endmodule
